>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding-window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

   // width of the window size field on the csr channel
   localparam int CFG_BITS = 5;

   // window size after reset
   localparam int WINDOW_SIZE_RESET = 3;

   // flags a cell hands to its right-hand neighbor
   typedef struct packed {
      logic kill;   // the leaving entry sits at this cell or to its left
      logic bgt;    // entry after removal at this position is above the sample
   } swm_link_type;

endpackage

>>> rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One position of the sorted window: holds a sample and its age, and on each
// transaction takes its new entry from itself, a neighbor or the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int AGE_BITS    = 4
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          occupied,
   input  logic                          full,
   input  logic [AGE_BITS-1:0]           oldest_age,
   input  swm_pkg::swm_link_type         left_link,
   input  logic signed [SAMPLE_BITS-1:0] left_b_value,
   input  logic [AGE_BITS-1:0]           left_b_age,
   input  logic signed [SAMPLE_BITS-1:0] right_value,
   input  logic [AGE_BITS-1:0]           right_age,
   input  logic                          right_gt,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [AGE_BITS-1:0]           age,
   output logic                          gt,
   output swm_pkg::swm_link_type         link,
   output logic signed [SAMPLE_BITS-1:0] b_value,
   output logic [AGE_BITS-1:0]           b_age
);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_BITS-1:0]           age_ff, age_in;
   logic                          del;

   always_comb begin
      // an empty position counts as above every sample
      gt        = !occupied || (value_ff > sample);
      del       = full && occupied && (age_ff == oldest_age);
      link.kill = left_link.kill || del;
      // close the gap left by the leaving entry
      b_value   = link.kill ? right_value : value_ff;
      b_age     = link.kill ? right_age : age_ff;
      link.bgt  = link.kill ? right_gt : gt;
      if (!link.bgt) begin
         value_in = b_value;
         age_in   = b_age + AGE_BITS'(1);
      end else if (!left_link.bgt) begin
         value_in = sample;
         age_in   = '0;
      end else begin
         value_in = left_b_value;
         age_in   = left_b_age + AGE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

>>> rtl/swm_median.sv
// ----------------------------------------------------------------------------
// swm_median
// Picks the two middle entries of the sorted window and adds them, which
// gives the median with one fractional bit.
// ----------------------------------------------------------------------------
module swm_median #(
   parameter int WINDOW_MAX  = 16,
   parameter int SAMPLE_BITS = 32
) (
   input  logic signed [SAMPLE_BITS-1:0] values [WINDOW_MAX],
   input  logic [WINDOW_MAX-1:0]         lo_sel,
   input  logic [WINDOW_MAX-1:0]         hi_sel,
   output logic signed [SAMPLE_BITS:0]   median_doubled
);

   logic [SAMPLE_BITS-1:0] lo_value;
   logic [SAMPLE_BITS-1:0] hi_value;

   always_comb begin
      lo_value = '0;
      hi_value = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         lo_value = lo_value | (values[i] & {SAMPLE_BITS{lo_sel[i]}});
         hi_value = hi_value | (values[i] & {SAMPLE_BITS{hi_sel[i]}});
      end
      // for an odd size both selects point at the middle entry
      median_doubled = $signed({lo_value[SAMPLE_BITS-1], lo_value})
                     + $signed({hi_value[SAMPLE_BITS-1], hi_value});
   end

endmodule

>>> rtl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Sliding-window median filter over a stream of signed samples, built as a
// row of cells that keep the window sorted.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   req     | in        | req_valid/req_ready, req_sample, req_start_of_stream
//   rsp     | out       | rsp_valid/rsp_ready, rsp_median_doubled
//   csr     | in        | csr_valid/csr_ready, csr_window_size
//
// One sample per cycle while req_ready is high: the cell row removes the
// oldest entry of a full window and inserts the new one in the cycle of the
// transaction; with the window full, the median is added up from the cells
// into the output register when that is free, which raises rsp_valid.
// req_ready drops only while a result waits in the cells and the output
// register is still held by rsp_ready low.
// Reset clears the window fill and sets a window size of three; no clear pass.
// ----------------------------------------------------------------------------
module sliding_window_median #(
   parameter int WINDOW_MAX  = 16,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  logic                               req_start_of_stream,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS:0]        rsp_median_doubled,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swm_pkg::CFG_BITS-1:0]       csr_window_size
);

   localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
   localparam int AGE_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int K_RESET  = (swm_pkg::WINDOW_SIZE_RESET > WINDOW_MAX) ?
                             WINDOW_MAX : swm_pkg::WINDOW_SIZE_RESET;

   logic [CNT_BITS-1:0] k_ff, k_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS:0] rsp_median_ff;

   logic [CNT_BITS-1:0] k_csr;
   logic [CNT_BITS-1:0] fill_now;
   logic [CNT_BITS-1:0] lo_idx, hi_idx;
   logic [AGE_BITS-1:0] oldest_age;
   logic                full;
   logic                accept;
   logic                move;
   logic                csr_write;

   logic [WINDOW_MAX-1:0] occupied;
   logic [WINDOW_MAX-1:0] lo_sel, hi_sel;

   logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
   logic [AGE_BITS-1:0]           cell_age   [WINDOW_MAX];
   logic                          cell_gt    [WINDOW_MAX];
   swm_pkg::swm_link_type         cell_link  [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] cell_b_value [WINDOW_MAX];
   logic [AGE_BITS-1:0]           cell_b_age   [WINDOW_MAX];

   logic signed [SAMPLE_BITS:0]   median;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // pending result moves to the output register when that is free
   assign move      = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || move;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (csr_window_size == '0) begin
         k_csr = CNT_BITS'(1);
      end else if (32'(csr_window_size) > 32'(WINDOW_MAX)) begin
         k_csr = CNT_BITS'(WINDOW_MAX);
      end else begin
         k_csr = CNT_BITS'(csr_window_size);
      end

      // a start flag empties the window ahead of its own sample
      fill_now   = req_start_of_stream ? '0 : fill_ff;
      full       = (fill_now == k_ff);
      oldest_age = AGE_BITS'(k_ff - CNT_BITS'(1));
      lo_idx     = (k_ff - CNT_BITS'(1)) >> 1;
      hi_idx     = k_ff >> 1;

      k_in    = csr_write ? k_csr : k_ff;
      fill_in = fill_ff;
      pend_in = move ? 1'b0 : pend_ff;
      if (csr_write) begin
         fill_in = '0;
      end else if (accept) begin
         fill_in = full ? k_ff : fill_now + CNT_BITS'(1);
         pend_in = (fill_in == k_ff);
      end

      rsp_valid_in = move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= CNT_BITS'(K_RESET);
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_median_ff <= median;
      end
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_pkg::swm_link_type         left_link;
      logic signed [SAMPLE_BITS-1:0] left_b_value;
      logic [AGE_BITS-1:0]           left_b_age;
      logic signed [SAMPLE_BITS-1:0] right_value;
      logic [AGE_BITS-1:0]           right_age;
      logic                          right_gt;

      assign occupied[i] = (CNT_BITS'(i) < fill_now);
      assign lo_sel[i]   = (CNT_BITS'(i) == lo_idx);
      assign hi_sel[i]   = (CNT_BITS'(i) == hi_idx);

      if (i == 0) begin : g_left_end
         assign left_link    = '{kill: 1'b0, bgt: 1'b0};
         assign left_b_value = '0;
         assign left_b_age   = '0;
      end else begin : g_left
         assign left_link    = cell_link[i-1];
         assign left_b_value = cell_b_value[i-1];
         assign left_b_age   = cell_b_age[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_right_end
         assign right_value = '0;
         assign right_age   = '0;
         assign right_gt    = 1'b1;
      end else begin : g_right
         assign right_value = cell_value[i+1];
         assign right_age   = cell_age[i+1];
         assign right_gt    = cell_gt[i+1];
      end

      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS)
      ) u_cell (
         .clock        (clock),
         .load         (accept),
         .sample       (req_sample),
         .occupied     (occupied[i]),
         .full         (full),
         .oldest_age   (oldest_age),
         .left_link    (left_link),
         .left_b_value (left_b_value),
         .left_b_age   (left_b_age),
         .right_value  (right_value),
         .right_age    (right_age),
         .right_gt     (right_gt),
         .value        (cell_value[i]),
         .age          (cell_age[i]),
         .gt           (cell_gt[i]),
         .link         (cell_link[i]),
         .b_value      (cell_b_value[i]),
         .b_age        (cell_b_age[i])
      );
   end

   swm_median #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_median (
      .values         (cell_value),
      .lo_sel         (lo_sel),
      .hi_sel         (hi_sel),
      .median_doubled (median)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = rsp_median_ff;

endmodule
